### design/eitp_pkg.sv
// ----------------------------------------------------------------------------
// eitp_pkg
// shared types, constants and the crc byte update for the header parser
// ----------------------------------------------------------------------------
package eitp_pkg;

	localparam int MAX_FRAME_BYTES = 16384;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int HDR_KEEP        = 38;
	localparam int ETH_LEN         = 14;
	localparam int IP_END          = 34;
	localparam int TCP_END         = 54;
	localparam int CRC_MIN         = 58;
	localparam int TAIL_LEN        = 4;
	localparam int PAYLOAD_W       = 14;

	localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_TOP      = 32'h8000_0000;
	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  IP_PROTO_TCP = 8'd6;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT_ETH = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_SHORT_IP  = 3'd3,
		ST_NOT_TCP   = 3'd4,
		ST_SHORT_TCP = 3'd5
	} status_t;

	// frame state as it stands after the current byte
	typedef struct packed {
		logic [CNT_W-1:0]              len;
		logic [31:0]                   crc;
		logic [31:0]                   tail;
		logic [HDR_KEEP-1:0][7:0]      hdr;
	} frame_view_t;

	// msb-first crc-32 over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {b, 24'd0};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 32'd0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

### design/eth_ipv4_tcp_header_parser.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser
// byte-wide ethernet / ipv4 / tcp header field capture with crc-32 check
// ----------------------------------------------------------------------------
// usage
//   s_* carries the frame, one byte per beat, s_tlast on the final byte.
//   m_* carries one result beat per frame: the status code on m_tuser and
//   the captured header fields, payload size and crc verdict on m_tdata.
//   bytes that never produce a result (all but the last) cost nothing on m_*.
// throughput
//   one byte per clock, while no final byte waits on a blocked result. a
//   byte is taken into the input register, where the field, status and crc
//   update logic (eight crc bit steps per byte) runs; the final byte's
//   result then loads into the result register, which drives m_tvalid.
// stalls
//   the result register holds while m_tready is low; a following non-final
//   byte still moves on, and only a second final byte waits in the input
//   register, which drops s_tready until the pending result is taken.
// reset
//   arst_n clears both registers' valid flags and returns the frame state to
//   its start: zero count, crc all ones, empty tail and header bytes.
//   the same state is restored after every final byte.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_parser
	import eitp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [231:0] m_tdata,   // dest_mac, src_mac, ether_type, ip_protocol, src_ip,
	                                // dst_ip, src_port, dst_port, payload_bytes,
	                                // crc_checked, crc_good (lowest bit first)
	output logic [2:0]   m_tuser    // [2:0] status
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// result register
	logic         m_valid_q;
	logic [231:0] m_data_q;
	status_t      m_status_q;

	logic        adv;
	frame_view_t view;

	// field and status logic
	logic [15:0]          ether_type;
	logic [7:0]           ip_protocol;
	status_t              status;
	logic                 crc_checked;
	logic                 crc_good;
	logic [PAYLOAD_W-1:0] payload_bytes;
	logic [CNT_W-1:0]     payload_full;
	logic [231:0]         result_data;

	// a non-final byte always moves on; a final one needs room in the result register
	assign adv      = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	eitp_frame_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (byte_s1),
		.last      (last_s1),
		.view      (view)
	);

	always_comb begin
		ether_type  = {view.hdr[12], view.hdr[13]};
		ip_protocol = view.hdr[23];

		// checks in priority order, length first at each layer
		if (view.len < CNT_W'(ETH_LEN)) begin
			status = ST_SHORT_ETH;
		end else if (ether_type != ETYPE_IPV4) begin
			status = ST_NOT_IPV4;
		end else if (view.len < CNT_W'(IP_END)) begin
			status = ST_SHORT_IP;
		end else if (ip_protocol != IP_PROTO_TCP) begin
			status = ST_NOT_TCP;
		end else if (view.len < CNT_W'(TCP_END)) begin
			status = ST_SHORT_TCP;
		end else begin
			status = ST_OK;
		end

		crc_checked   = (status == ST_OK) && (view.len >= CNT_W'(CRC_MIN));
		payload_full  = view.len - CNT_W'(CRC_MIN);
		payload_bytes = crc_checked ? payload_full[PAYLOAD_W-1:0] : '0;
		crc_good      = crc_checked && (view.tail == view.crc);

		result_data = {
			crc_good,
			crc_checked,
			payload_bytes,
			{view.hdr[36], view.hdr[37]},
			{view.hdr[34], view.hdr[35]},
			{view.hdr[30], view.hdr[31], view.hdr[32], view.hdr[33]},
			{view.hdr[26], view.hdr[27], view.hdr[28], view.hdr[29]},
			ip_protocol,
			ether_type,
			{view.hdr[6], view.hdr[7], view.hdr[8], view.hdr[9], view.hdr[10], view.hdr[11]},
			{view.hdr[0], view.hdr[1], view.hdr[2], view.hdr[3], view.hdr[4], view.hdr[5]}
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			m_data_q   <= result_data;
			m_status_q <= status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

	// crc verdict only ever comes with a checked crc
	a_good_needs_checked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[231] || m_tdata[230]))
		else $error("crc_good set without crc_checked");

	// a checked crc only on an ok status
	a_checked_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[230]) |-> (m_tuser == ST_OK))
		else $error("crc_checked set on a failing status");

	// unchecked frames report no payload
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[230]) |-> (m_tdata[229:216] == '0))
		else $error("payload size reported on an unchecked frame");

	// the input only stalls behind a final byte waiting on a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && m_valid_q && !m_tready))
		else $error("input stalled without a pending result");

	// a final byte that moves on shows up as a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> m_tvalid)
		else $error("final byte produced no result");

endmodule

### design/eitp_frame_track.sv
// ----------------------------------------------------------------------------
// eitp_frame_track
// per-frame state: byte count, running crc, tail bytes and header bytes
// ----------------------------------------------------------------------------
module eitp_frame_track
	import eitp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output frame_view_t view
);

	logic [CNT_W-1:0]         count_q;
	logic [31:0]              crc_q;
	logic [TAIL_LEN-1:0][7:0] tail_q;
	logic [HDR_KEEP-1:0][7:0] hdr_q;

	logic [CNT_W-1:0]         count_next;
	logic [31:0]              crc_next;
	logic [TAIL_LEN-1:0][7:0] tail_next;
	logic [HDR_KEEP-1:0][7:0] hdr_next;

	always_comb begin
		for (int i = 0; i < HDR_KEEP; i++) begin
			hdr_next[i] = (count_q == CNT_W'(i)) ? data_byte : hdr_q[i];
		end
		// oldest tail byte enters the crc once four bytes are held
		crc_next = (count_q >= CNT_W'(TAIL_LEN)) ? crc_byte(crc_q, tail_q[0]) : crc_q;
		for (int i = 0; i < TAIL_LEN - 1; i++) begin
			tail_next[i] = tail_q[i+1];
		end
		tail_next[TAIL_LEN-1] = data_byte;
		count_next = (count_q < CNT_W'(MAX_FRAME_BYTES)) ? count_q + CNT_W'(1) : count_q;
	end

	always_comb begin
		view.len  = count_next;
		view.crc  = crc_next;
		view.tail = {tail_next[0], tail_next[1], tail_next[2], tail_next[3]};
		view.hdr  = hdr_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
			tail_q  <= '0;
			hdr_q   <= '0;
		end else if (step) begin
			if (last) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
				tail_q  <= '0;
				hdr_q   <= '0;
			end else begin
				count_q <= count_next;
				crc_q   <= crc_next;
				tail_q  <= tail_next;
				hdr_q   <= hdr_next;
			end
		end
	end

endmodule
